[hw/rtl/lnwq_pkg.sv]
package lnwq_pkg;

  localparam int FIFO_DEPTH_DEFAULT = 32;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_LAST  = 3'd6;

  localparam logic [6:0] EN_BIT = 7'h40;
  localparam logic [6:0] RS_BIT = 7'h10;

  // One classified word handed from the front to the back.
  typedef struct packed {
    logic       send;
    logic       accepted;
    logic       tick_enable;
    logic [5:0] fill_count;
    logic [7:0] data;
  } job_t;

  // Port value for one step of the seven-write nibble sequence.
  function automatic logic [6:0] nibble_value(input logic [7:0] data, input logic [2:0] step);
    logic [6:0] hi;
    logic [6:0] lo;
    logic [6:0] v;
    hi = {3'b000, data[7:4]} | (data[7] ? 7'h00 : RS_BIT);
    lo = {3'b000, data[3:0]} | (data[7] ? 7'h00 : RS_BIT);
    unique case (step)
      3'd0:    v = hi;
      3'd1:    v = hi | EN_BIT;
      3'd2:    v = hi;
      3'd3:    v = lo;
      3'd4:    v = lo | EN_BIT;
      3'd5:    v = lo;
      default: v = 7'h00;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/lnwq_front.sv]
module lnwq_front #(
  parameter int FIFO_DEPTH = lnwq_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic           command,
  input  logic [7:0]     data_byte,
  output logic           job_valid,
  output lnwq_pkg::job_t job,
  input  logic           job_take
);
  import lnwq_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [AW-1:0] wr_idx, wr_idx_next;
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic [CW-1:0] count, count_next;
  logic          irq, irq_next;
  logic          store_en, acc, send;
  logic          accept;
  logic          job_send, job_acc, job_irq;
  logic [5:0]    job_fill;
  logic [7:0]    rd_data;

  assign full   = job_valid && !job_take;
  assign accept = push && !full;

  always_comb begin
    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx;
    count_next  = count;
    irq_next    = irq;
    store_en    = 1'b0;
    acc         = 1'b0;
    send        = 1'b0;
    if (command == CMD_ENQUEUE) begin
      if (count != CW'(FIFO_DEPTH)) begin
        store_en    = 1'b1;
        acc         = 1'b1;
        wr_idx_next = (wr_idx == AW'(FIFO_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
        count_next  = count + 1'b1;
      end
      if (count_next == CW'(1)) begin
        irq_next = 1'b1;
      end
    end else begin
      if (count == '0) begin
        irq_next = 1'b0;
      end else begin
        acc         = 1'b1;
        send        = 1'b1;
        rd_idx_next = (rd_idx == AW'(FIFO_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
        count_next  = count - 1'b1;
        if (count_next == '0) begin
          irq_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx    <= '0;
      rd_idx    <= '0;
      count     <= '0;
      irq       <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (accept) begin
        wr_idx    <= wr_idx_next;
        rd_idx    <= rd_idx_next;
        count     <= count_next;
        irq       <= irq_next;
        job_valid <= 1'b1;
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_send <= send;
      job_acc  <= acc;
      job_irq  <= irq_next;
      job_fill <= 6'(count_next);
      rd_data  <= mem[rd_idx];
      if (store_en) begin
        mem[wr_idx] <= data_byte;
      end
    end
  end

  assign job.send        = job_send;
  assign job.accepted    = job_acc;
  assign job.tick_enable = job_irq;
  assign job.fill_count  = job_fill;
  assign job.data        = rd_data;

endmodule

[hw/rtl/lnwq_job_queue.sv]
module lnwq_job_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_take,
  input  lnwq_pkg::job_t in_job,
  output logic           out_valid,
  output lnwq_pkg::job_t out_job,
  input  logic           out_pop
);
  import lnwq_pkg::*;

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] used;
  logic       do_push, do_pop;

  assign in_take   = in_valid && (used != 2'd2);
  assign out_valid = (used != 2'd0);
  assign out_job   = slots[rd_ptr];
  assign do_push   = in_take;
  assign do_pop    = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        used <= used + 2'd1;
      end else if (do_pop && !do_push) begin
        used <= used - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_job;
    end
  end

endmodule

[hw/rtl/lnwq_back.sv]
module lnwq_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  lnwq_pkg::job_t job,
  output logic           job_pop,
  output logic           empty,
  input  logic           pop,
  output logic           port_write,
  output logic [6:0]     port_value,
  output logic           last,
  output logic           accepted,
  output logic           tick_enable,
  output logic [5:0]     fill_count
);
  import lnwq_pkg::*;

  logic       out_valid;
  logic [2:0] step;
  logic       load;
  logic       last_c;

  assign empty   = !out_valid;
  assign load    = job_valid && (!out_valid || pop);
  assign last_c  = !job.send || (step == STEP_LAST);
  assign job_pop = load && last_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= STEP_FIRST;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= last_c ? STEP_FIRST : step + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      port_write  <= job.send;
      port_value  <= job.send ? nibble_value(job.data, step) : 7'h00;
      last        <= last_c;
      accepted    <= job.accepted;
      tick_enable <= job.tick_enable;
      fill_count  <= job.fill_count;
    end
  end

endmodule

[hw/rtl/lcd_nibble_write_queue_unit.sv]
// Channel   Direction  Handshake       Word
// input     in         push / full     command, data_byte
// result    out        pop / empty     port_write, port_value, last, accepted,
//                                      tick_enable, fill_count
//
// An enqueue gives one result word; a tick that finds a byte gives seven, one per cycle
// while pop is high; the back-end step counter holds the result side until all are taken.
// The first result passes the front job register, job queue and back output register.
// Synchronous reset empties the byte queue and clears the tick-enable flag.
// A two-entry job queue lets input words be taken while the result side is stalled.
module lcd_nibble_write_queue_unit #(
  parameter int FIFO_DEPTH = lnwq_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       command,
  input  logic [7:0] data_byte,
  output logic       empty,
  input  logic       pop,
  output logic       port_write,
  output logic [6:0] port_value,
  output logic       last,
  output logic       accepted,
  output logic       tick_enable,
  output logic [5:0] fill_count
);
  import lnwq_pkg::*;

  logic front_valid, front_take;
  job_t front_job;
  logic back_valid, back_pop;
  job_t back_job;

  lnwq_front #(.FIFO_DEPTH(FIFO_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .data_byte (data_byte),
    .job_valid (front_valid),
    .job       (front_job),
    .job_take  (front_take)
  );

  lnwq_job_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_take   (front_take),
    .in_job    (front_job),
    .out_valid (back_valid),
    .out_job   (back_job),
    .out_pop   (back_pop)
  );

  lnwq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (back_valid),
    .job         (back_job),
    .job_pop     (back_pop),
    .empty       (empty),
    .pop         (pop),
    .port_write  (port_write),
    .port_value  (port_value),
    .last        (last),
    .accepted    (accepted),
    .tick_enable (tick_enable),
    .fill_count  (fill_count)
  );

endmodule

[hw/rtl/lnwq_checker.sv]
module lnwq_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       port_write,
  input logic [6:0] port_value,
  input logic       last,
  input logic       accepted,
  input logic [5:0] fill_count
);

  // A result word that is not taken stays on the ports.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(port_value) && $stable(last)))
    else $error("result word changed while stalled");

  // A word that is not a port write is the only word of its input.
  a_single: assert property (@(posedge clk) disable iff (rst)
    (!empty && !port_write) |-> (last && port_value == 7'h00))
    else $error("non-write result is not a lone cleared word");

  // A port write only comes from a byte that was sent.
  a_sent: assert property (@(posedge clk) disable iff (rst)
    (!empty && port_write) |-> accepted)
    else $error("port write without a sent byte");

  // Within one sent byte the seven writes follow back to back with one fill count.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && port_write && !last) |=>
      (!empty && port_write && $stable(fill_count)))
    else $error("nibble write sequence broken");

  // Reset leaves nothing to read.
  a_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result present right after reset");

endmodule

bind lcd_nibble_write_queue_unit lnwq_checker u_lnwq_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .port_write (port_write),
  .port_value (port_value),
  .last       (last),
  .accepted   (accepted),
  .fill_count (fill_count)
);

[verif/lcd_nibble_write_queue_unit_tb.sv]
`timescale 1ns / 100ps

typedef struct packed {
  logic       port_write;
  logic [6:0] port_value;
  logic       last;
  logic       accepted;
  logic       tick_enable;
  logic [5:0] fill_count;
} lcd_word_t;

class lcd_write_tracker;
  localparam int DEPTH = lnwq_pkg::FIFO_DEPTH_DEFAULT;

  logic [7:0] ring [DEPTH];
  int         wr_pos;
  int         rd_pos;
  int         held;
  logic       irq_on;
  lcd_word_t  queued_writes [$];
  int         errors;

  function new();
    wr_pos = 0;
    rd_pos = 0;
    held   = 0;
    irq_on = 1'b0;
    errors = 0;
  endfunction

  function int pending();
    return queued_writes.size();
  endfunction

  function void add_word(logic pw, logic [6:0] pv, logic lst, logic acc);
    lcd_word_t w;
    w.port_write  = pw;
    w.port_value  = pv;
    w.last        = lst;
    w.accepted    = acc;
    w.tick_enable = irq_on;
    w.fill_count  = 6'(held);
    queued_writes.push_back(w);
  endfunction

  function void note_word(logic cmd, logic [7:0] data);
    logic       acc;
    logic [7:0] b;
    logic [6:0] hi;
    logic [6:0] lo;
    if (cmd == lnwq_pkg::CMD_ENQUEUE) begin
      acc = 1'b0;
      if (held < DEPTH) begin
        ring[wr_pos] = data;
        wr_pos = (wr_pos + 1 >= DEPTH) ? 0 : wr_pos + 1;
        held++;
        acc = 1'b1;
      end
      if (held == 1) irq_on = 1'b1;
      add_word(1'b0, 7'h00, 1'b1, acc);
    end else if (held == 0) begin
      irq_on = 1'b0;
      add_word(1'b0, 7'h00, 1'b1, 1'b0);
    end else begin
      b  = ring[rd_pos];
      hi = {3'b000, b[7:4]};
      if (!b[7]) hi = hi | lnwq_pkg::RS_BIT;
      lo = (hi & lnwq_pkg::RS_BIT) | {3'b000, b[3:0]};
      rd_pos = (rd_pos + 1 >= DEPTH) ? 0 : rd_pos + 1;
      held--;
      if (held == 0) irq_on = 1'b0;
      add_word(1'b1, hi, 1'b0, 1'b1);
      add_word(1'b1, hi | lnwq_pkg::EN_BIT, 1'b0, 1'b1);
      add_word(1'b1, hi, 1'b0, 1'b1);
      add_word(1'b1, lo, 1'b0, 1'b1);
      add_word(1'b1, lo | lnwq_pkg::EN_BIT, 1'b0, 1'b1);
      add_word(1'b1, lo, 1'b0, 1'b1);
      add_word(1'b1, 7'h00, 1'b1, 1'b1);
    end
  endfunction

  function void check_word(lcd_word_t got);
    lcd_word_t want;
    if (queued_writes.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected word: pw=%0d pv=%h last=%0d acc=%0d te=%0d fill=%0d",
                 got.port_write, got.port_value, got.last, got.accepted,
                 got.tick_enable, got.fill_count);
      return;
    end
    want = queued_writes.pop_front();
    if (got.port_write !== want.port_write || got.port_value !== want.port_value ||
        got.last !== want.last || got.accepted !== want.accepted ||
        got.tick_enable !== want.tick_enable || got.fill_count !== want.fill_count) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp pw=%0d pv=%h last=%0d acc=%0d te=%0d fill=%0d / got pw=%0d pv=%h last=%0d acc=%0d te=%0d fill=%0d",
                 want.port_write, want.port_value, want.last, want.accepted,
                 want.tick_enable, want.fill_count, got.port_write, got.port_value,
                 got.last, got.accepted, got.tick_enable, got.fill_count);
    end
  endfunction
endclass

module lcd_nibble_write_queue_unit_tb;
  import lnwq_pkg::*;

  localparam int RANDOM_WORDS = 230;
  localparam int CALM_WORDS   = 30;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;

  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic       command = CMD_ENQUEUE;
  logic [7:0] data_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic       port_write;
  logic [6:0] port_value;
  logic       last;
  logic       accepted;
  logic       tick_enable;
  logic [5:0] fill_count;

  logic hold_go = 1'b0;
  logic calm = 1'b0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   gap_left = 0;
  int   idle_cycles = 0;

  lcd_write_tracker tracker = new();

  lcd_nibble_write_queue_unit #(
    .FIFO_DEPTH(FIFO_DEPTH_DEFAULT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .command(command),
    .data_byte(data_byte),
    .empty(empty),
    .pop(pop),
    .port_write(port_write),
    .port_value(port_value),
    .last(last),
    .accepted(accepted),
    .tick_enable(tick_enable),
    .fill_count(fill_count)
  );

  always #5 clk = ~clk;

  task automatic send_word(logic cmd, logic [7:0] data);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    push      <= 1'b1;
    command   <= cmd;
    data_byte <= data;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.note_word(cmd, data);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        tracker.check_word({port_write, port_value, last, accepted, tick_enable, fill_count});
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 17) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[lcd_nibble_write_queue_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    mix_e mode;
    logic cmd;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(CMD_TICK, 8'($urandom));
    send_word(CMD_ENQUEUE, 8'h00);
    send_word(CMD_ENQUEUE, 8'hFF);
    send_word(CMD_ENQUEUE, 8'h80);
    send_word(CMD_ENQUEUE, 8'h7F);
    send_word(CMD_ENQUEUE, 8'h0F);
    send_word(CMD_ENQUEUE, 8'hF0);
    repeat (7) send_word(CMD_TICK, 8'($urandom));
    send_word(CMD_ENQUEUE, 8'h5A);
    send_word(CMD_TICK, 8'hA5);

    hold_go <= 1'b1;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      case (i / 46)
        0, 3:    mode = MIX_FILL;
        2:       mode = MIX_EVEN;
        default: mode = MIX_DRAIN;
      endcase
      if (i >= RANDOM_WORDS - CALM_WORDS) calm <= 1'b1;
      case (mode)
        MIX_FILL:  cmd = ($urandom_range(0, 7) == 0) ? CMD_TICK : CMD_ENQUEUE;
        MIX_DRAIN: cmd = ($urandom_range(0, 3) == 0) ? CMD_ENQUEUE : CMD_TICK;
        default:   cmd = $urandom_range(0, 1) ? CMD_TICK : CMD_ENQUEUE;
      endcase
      send_word(cmd, 8'($urandom));
    end
    push <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[lcd_nibble_write_queue_unit] OK");
    end else begin
      $display("[lcd_nibble_write_queue_unit] ERROR");
    end
    $finish;
  end
endmodule
